// ===== hw/rtl/serial_line_edit_buffer_macros.svh =====
// Assertion macros used by the serial line edit buffer controller.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SERIAL_LINE_EDIT_BUFFER_MACROS_SVH
`define SERIAL_LINE_EDIT_BUFFER_MACROS_SVH

// Implication checked in the same cycle.
`define SLB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle.
`define SLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/slb_pkg.sv =====
// Package for the serial line edit buffer: result kinds, character codes and
// the command and status structures between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package slb_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 5;

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BELL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd3;

  localparam logic [BYTE_W-1:0] CODE_BS  = 8'd127;
  localparam logic [BYTE_W-1:0] CODE_BEL = 8'd7;
  localparam logic [BYTE_W-1:0] CODE_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CODE_CR  = 8'd13;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              cap_byte;   // capture the incoming byte
    logic              dec_wp;     // backspace: step the write pointer back
    logic              do_store;   // write the byte and advance the write pointer
    logic              load_line;  // load the line counters from the fill level
    logic              rd_issue;   // read the ring at the read pointer and advance it
    logic              rp_to_wp;   // empty the ring after a line end
    logic              out_load;   // load the output register
    logic [KIND_W-1:0] out_kind;
    logic              out_last;
  } slb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_bs;
    logic is_term;
    logic empty;
    logic full;
    logic rem_zero;
    logic out_free;
  } slb_stat_t;

endpackage

// ===== hw/rtl/slb_in_if.sv =====
// Input channel interface of the serial line edit buffer: one received byte per transfer.
// Depends on slb_pkg.
`timescale 1ns / 1ps

interface slb_in_if;
  logic                       valid;
  logic                       ready;
  logic [slb_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/slb_out_if.sv =====
// Result channel interface of the serial line edit buffer: one result item per transfer.
// Depends on slb_pkg.
`timescale 1ns / 1ps

interface slb_out_if;
  logic                       valid;
  logic                       ready;
  logic [slb_pkg::KIND_W-1:0] kind;
  logic [slb_pkg::BYTE_W-1:0] byte_value;
  logic [slb_pkg::LEN_W-1:0]  line_length;
  logic                       last;

  modport source (output valid, output kind, output byte_value, output line_length,
                  output last, input ready);
  modport sink (input valid, input kind, input byte_value, input line_length,
                input last, output ready);
endinterface

// ===== hw/rtl/slb_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module slb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/slb_datapath.sv =====
// Datapath of the serial line edit buffer: ring pointers, character RAM,
// line counters and the output register. Depends on slb_pkg and slb_ram.
`timescale 1ns / 1ps

module slb_datapath #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  slb_pkg::slb_cmd_t          cmd,
  output slb_pkg::slb_stat_t         st,
  input  logic [slb_pkg::BYTE_W-1:0] in_byte,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [slb_pkg::KIND_W-1:0] out_kind,
  output logic [slb_pkg::BYTE_W-1:0] out_byte,
  output logic [slb_pkg::LEN_W-1:0]  out_len,
  output logic                       out_last
);
  import slb_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [PW-1:0]     rem_r, rem_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;
  logic [PW:0]       held;
  logic [BYTE_W-1:0] rd_data;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
  endfunction

  slb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.do_store),
    .waddr (wp_r),
    .wdata (byte_r),
    .re    (cmd.rd_issue),
    .raddr (rp_r),
    .rdata (rd_data)
  );

  // Fill level of the ring, modulo DEPTH.
  always_comb begin
    if (wp_r >= rp_r) begin
      held = {1'b0, wp_r} - {1'b0, rp_r};
    end else begin
      held = {1'b0, wp_r} + (PW + 1)'(DEPTH) - {1'b0, rp_r};
    end
  end

  always_comb begin
    st.is_bs    = (byte_r == CODE_BS);
    st.is_term  = (byte_r == CODE_LF) || (byte_r == CODE_CR);
    st.empty    = (wp_r == rp_r);
    st.full     = (held == (PW + 1)'(DEPTH - 1));
    st.rem_zero = (rem_r == '0);
    st.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    byte_nxt      = cmd.cap_byte ? in_byte : byte_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    rem_nxt       = rem_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;

    if (cmd.dec_wp) begin
      wp_nxt = ptr_dec(wp_r);
    end else if (cmd.do_store) begin
      wp_nxt = ptr_inc(wp_r);
    end

    // The fill level before the terminator is stored is the line length.
    if (cmd.load_line) begin
      rem_nxt = held[PW-1:0];
      len_nxt = LEN_W'(held);
    end

    if (cmd.rd_issue) begin
      rp_nxt  = ptr_inc(rp_r);
      rem_nxt = rem_r - PW'(1);
    end else if (cmd.rp_to_wp) begin
      rp_nxt = wp_r;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = cmd.out_kind;
      out_last_nxt  = cmd.out_last;
      out_len_nxt   = '0;
      case (cmd.out_kind)
        KIND_ECHO: out_byte_nxt = byte_r;
        KIND_BELL: out_byte_nxt = CODE_BEL;
        KIND_CHAR: out_byte_nxt = rd_data;
        KIND_END: begin
          out_byte_nxt = '0;
          out_len_nxt  = len_r;
        end
        default: out_byte_nxt = '0;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    len_r      <= len_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_len   = out_len_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/slb_ctrl.sv =====
// Controller state machine of the serial line edit buffer.
// Depends on slb_pkg and serial_line_edit_buffer_macros.svh.
`timescale 1ns / 1ps
`include "serial_line_edit_buffer_macros.svh"

module slb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  slb_pkg::slb_stat_t st,
  output slb_pkg::slb_cmd_t  cmd
);
  import slb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHAR = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_byte = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
          if (st.is_bs) begin
            if (!st.empty) begin
              cmd.dec_wp   = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_kind = KIND_ECHO;
              cmd.out_last = 1'b1;
            end
          end else if (st.full) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_BELL;
            cmd.out_last = 1'b1;
          end else begin
            cmd.do_store = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_ECHO;
            cmd.out_last = !st.is_term;
            if (st.is_term) begin
              cmd.load_line = 1'b1;
              state_nxt     = S_RD;
            end
          end
        end
      end
      S_RD: begin
        if (st.rem_zero) begin
          state_nxt = S_END;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_CHAR;
        end
      end
      S_CHAR: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_CHAR;
          state_nxt    = S_RD;
        end
      end
      S_END: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_END;
          cmd.out_last = 1'b1;
          cmd.rp_to_wp = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SLB_ASSERT_SAME(a_load_needs_slot, cmd.out_load, st.out_free, "output register overwritten")
  `SLB_ASSERT_SAME(a_store_not_full, cmd.do_store, !st.full, "byte stored into a full ring")
  `SLB_ASSERT_SAME(a_read_in_line, cmd.rd_issue, !st.rem_zero, "ring read past the line")
  `SLB_ASSERT_NEXT(a_end_empties, cmd.out_load && (cmd.out_kind == KIND_END), st.empty,
    "ring not empty after a line end")

endmodule

// ===== hw/rtl/serial_line_edit_buffer.sv =====
// Serial line edit buffer: a received byte is registered, then its echo or bell, if any,
// is loaded into the output register once that is free; a completed line of n
// characters follows as n character items and a line end. One input byte is handled
// at a time, bounded by the single RAM read port feeding the output register.
// Synchronous active-low reset empties the ring and clears the output valid flag;
// the character RAM itself is not cleared and is only read where it was written.
`timescale 1ns / 1ps

module serial_line_edit_buffer #(
  parameter int DEPTH = 32
) (
  input logic     clk,
  input logic     rst_n,
  slb_in_if.sink  in_ch,
  slb_out_if.source out_ch
);
  import slb_pkg::*;

  // The controller sequences each received byte: it takes one transfer while idle,
  // then decides between backspace, bell and store. A stored CR or LF starts the
  // line sweep, which reads the ring one character at a time through the RAM's
  // registered port. No CR or LF ever stays in the ring once an item is finished,
  // so the terminator that has just been stored is always the first one found.
  slb_cmd_t  cmd;
  slb_stat_t st;

  slb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath owns the pointers, the RAM and the output register, so a result
  // can wait for its transfer while the next byte is already being taken in.
  slb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_byte   (in_ch.rx_byte),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_kind  (out_ch.kind),
    .out_byte  (out_ch.byte_value),
    .out_len   (out_ch.line_length),
    .out_last  (out_ch.last)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for serial_line_edit_buffer: directed, back-pressure and random
// line-editing traffic, checked against an in-bench predictor. Depends on slb_pkg,
// slb_in_if, slb_out_if and the serial_line_edit_buffer RTL.
`timescale 1ns / 1ps

module tb;
  import slb_pkg::*;

  localparam int RING_DEPTH       = 32;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 2 * RING_DEPTH + 40;
  localparam int ITEMS_PER_PHASE  = 118;

  // One result transfer as the block presents it.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] byte_value;
    logic [LEN_W-1:0]  line_length;
    logic              last;
  } line_result_t;

  logic clk;
  logic rst_n;

  slb_in_if  rx_if ();
  slb_out_if res_if ();

  serial_line_edit_buffer #(
    .DEPTH (RING_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (rx_if),
    .out_ch (res_if)
  );

  // Predictor state. The ring is kept as a queue of held characters, oldest first, so
  // the read pointer is the front and the write pointer sits just past the back.
  logic [BYTE_W-1:0] ring_q[$];
  line_result_t      expected_q[$];

  int error_count     = 0;
  int useful_items    = 0;  // accepted bytes that caused at least one result
  int stall_cycles    = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int recv_hold_left  = 0;

  // The clock starts low so that the first edge the block sees is a rising one.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic line_result_t make_result(input logic [KIND_W-1:0] kind,
                                               input logic [BYTE_W-1:0] value,
                                               input logic [LEN_W-1:0]  len);
    line_result_t r;
    r.kind        = kind;
    r.byte_value  = value;
    r.line_length = len;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic is_line_end(input logic [BYTE_W-1:0] c);
    return (c == CODE_CR) || (c == CODE_LF);
  endfunction

  // Works out every result that one accepted byte causes and queues them in order.
  // A backspace on an empty ring causes nothing at all, and a full ring answers with a
  // bell and never scans for a line, so only a freshly stored byte can complete a line.
  task automatic predict_line_edit(input logic [BYTE_W-1:0] c);
    line_result_t batch[$];
    line_result_t tail;
    logic         stored;
    int           term_pos;
    stored   = 1'b0;
    term_pos = -1;
    if (c == CODE_BS) begin
      if (ring_q.size() != 0) begin
        void'(ring_q.pop_back());
        batch.push_back(make_result(KIND_ECHO, c, '0));
      end
    end else if (ring_q.size() < RING_DEPTH - 1) begin
      ring_q.push_back(c);
      batch.push_back(make_result(KIND_ECHO, c, '0));
      stored = 1'b1;
    end else begin
      batch.push_back(make_result(KIND_BELL, CODE_BEL, '0));
    end

    if (stored) begin
      foreach (ring_q[i]) begin
        if (term_pos < 0 && is_line_end(ring_q[i])) term_pos = i;
      end
      if (term_pos >= 0) begin
        // The characters before the terminator leave the ring as the line, then the
        // line end carries their count. An empty line gives the line end alone.
        repeat (term_pos) batch.push_back(make_result(KIND_CHAR, ring_q.pop_front(), '0));
        batch.push_back(make_result(KIND_END, '0, LEN_W'(term_pos)));
        while (ring_q.size() != 0 && is_line_end(ring_q[0])) void'(ring_q.pop_front());
      end
    end

    if (batch.size() != 0) begin
      tail      = batch.pop_back();
      tail.last = 1'b1;
      batch.push_back(tail);
      foreach (batch[i]) expected_q.push_back(batch[i]);
      useful_items++;
    end
  endtask

  // Compares one result transfer with the oldest expectation, field by field.
  task automatic check_result();
    line_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result with nothing expected: kind %0d byte %0d length %0d last %0b",
               $time, res_if.kind, res_if.byte_value, res_if.line_length, res_if.last);
      error_count++;
    end else begin
      want = expected_q.pop_front();
      if (res_if.kind !== want.kind) begin
        $display("%0t: kind expected %0d, actual %0d", $time, want.kind, res_if.kind);
        error_count++;
      end
      if (res_if.byte_value !== want.byte_value) begin
        $display("%0t: byte_value expected %0d, actual %0d",
                 $time, want.byte_value, res_if.byte_value);
        error_count++;
      end
      if (res_if.line_length !== want.line_length) begin
        $display("%0t: line_length expected %0d, actual %0d",
                 $time, want.line_length, res_if.line_length);
        error_count++;
      end
      if (res_if.last !== want.last) begin
        $display("%0t: last expected %0b, actual %0b", $time, want.last, res_if.last);
        error_count++;
      end
    end
  endtask

  // Both channels are sampled at the rising edge. The input transfer is predicted
  // before the output transfer is checked, although the block's latency means that a
  // result can never belong to a byte taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rx_if.valid && rx_if.ready) predict_line_edit(rx_if.rx_byte);
      if (res_if.valid && res_if.ready) check_result();
    end
  end

  // The watchdog counts cycles in which neither channel moves a transfer. It must
  // outlast the long hold-off of the back-pressure test.
  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // The receiver changes ready at the falling edge. A requested hold-off keeps it low
  // for a counted stretch; otherwise it idles at the current rate.
  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      out_ready_low();
      recv_hold_left--;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic out_ready_low();
    res_if.ready <= 1'b0;
  endtask

  // Offers one byte until it is taken. Idle cycles, if any, come before the byte is
  // offered, and valid is only ever written once per falling edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
  endtask

  // A random printable-or-not character that is neither a terminator nor a backspace.
  function automatic logic [BYTE_W-1:0] pick_text_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    while (is_line_end(b) || b == CODE_BS) b = BYTE_W'($urandom_range(0, 255));
    return b;
  endfunction

  // Extremes of the byte, backspace on an empty and a non-empty ring, empty lines from
  // either terminator, a CR LF pair, and the bell code stored as an ordinary character.
  task automatic test_directed_editing();
    send_byte(CODE_BS);         // empty ring: no result
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CODE_BS);         // removes the 0xFF again
    send_byte(CODE_BEL);        // stored like any other character
    send_byte(8'h80);
    send_byte(CODE_CR);         // line of three characters
    send_byte(CODE_CR);         // empty line
    send_byte(CODE_LF);         // empty line
    send_byte(8'h41);
    send_byte(CODE_CR);
    send_byte(CODE_LF);         // the LF of a CR LF pair ends an empty line of its own
    send_byte(8'h42);
    send_byte(8'h43);
    send_byte(CODE_BS);
    send_byte(CODE_BS);
    send_byte(CODE_BS);         // ring already empty again
    send_byte(CODE_LF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h7E);
    send_byte(8'h01);
    send_byte(CODE_LF);
  endtask

  // The receiver holds off for a long stretch while the ring is filled to its limit,
  // so the block stalls its input. Two extra bytes meet the full ring and ring the
  // bell; a backspace then makes room for the terminator, giving the longest line.
  task automatic test_full_ring_stall();
    recv_hold_left = LONG_HOLD_CYCLES;
    repeat (RING_DEPTH - 1) send_byte(pick_text_byte());
    send_byte(pick_text_byte());
    send_byte(CODE_CR);         // a terminator on a full ring is only a bell
    send_byte(CODE_BS);
    send_byte(CODE_CR);
  endtask

  // Mostly well-formed lines with random content and the odd backspace, a few of them
  // long enough to overflow the ring, mixed with bursts of arbitrary bytes.
  task automatic send_random_burst();
    int len;
    if (ring_q.size() > RING_DEPTH - 4) begin
      // A ring left full by an overlong line is trimmed so that lines can end again.
      repeat ($urandom_range(2, ring_q.size())) send_byte(CODE_BS);
    end
    if ($urandom_range(0, 99) < 80) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 36) : $urandom_range(0, 12);
      repeat (len) send_byte(($urandom_range(0, 9) == 0) ? CODE_BS : pick_text_byte());
      case ($urandom_range(0, 2))
        0: begin
          send_byte(CODE_CR);
        end
        1: begin
          send_byte(CODE_LF);
        end
        default: begin
          send_byte(CODE_CR);
          send_byte(CODE_LF);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Random traffic in three idling phases: a slow receiver, then a slow sender, then
  // neither side idling at all.
  task automatic test_random_traffic();
    int start;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      start = useful_items;
      while (useful_items - start < ITEMS_PER_PHASE) send_random_burst();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 82;
    test_directed_editing();
    test_full_ring_stall();
    test_random_traffic();

    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
